@@ design/fbcs_pkg.sv @@
// Package: shared types, constants and table functions for the floppy block sequencer.
package fbcs_pkg;

    localparam int MAX_DRIVES             = 8;
    localparam int MAX_BLOCKS_PER_REQUEST = 16;

    localparam int ADDR_W    = 5;
    localparam int IDX_W     = 18;
    localparam int SPT_W     = 7;
    localparam int SPS_W     = 6;
    localparam int TRK_W     = 8;
    localparam int OFF_W     = 13;
    localparam int DIV_CNT_W = $clog2(IDX_W);

    typedef enum logic [2:0] {
        REG_CARD_TYPE     = 3'd0,
        REG_DRIVE_NUMBER  = 3'd1,
        REG_DENSITY_CODE  = 3'd2,
        REG_SECTORS_SIDE  = 3'd3,
        REG_DOUBLE_SIDED  = 3'd4,
        REG_DOUBLE_STEP   = 3'd5,
        REG_SECTOR_BASE0  = 3'd6,
        REG_SECTOR_SIZE   = 3'd7
    } reg_idx_t;

    localparam logic [1:0] CARD_FIRST  = 2'd0;
    localparam logic [1:0] CARD_SECOND = 2'd1;
    localparam logic [1:0] CARD_EIGHT  = 2'd2;

    localparam logic [2:0] DEN_SD   = 3'd0;
    localparam logic [2:0] DEN_DD   = 3'd1;
    localparam logic [2:0] DEN_HD   = 3'd2;
    localparam logic [2:0] DEN_8SD  = 3'd3;
    localparam logic [2:0] DEN_8DD  = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BADDEN = 2'd1;
    localparam logic [1:0] STATUS_TRACK = 2'd2;

    localparam logic [7:0] SEL_NONE = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_EMIT = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic [1:0]       card_type;
        logic [2:0]       drive_number;
        logic [2:0]       density_code;
        logic [SPS_W-1:0] sectors_per_side;
        logic             double_sided;
        logic             double_step;
        logic             sector_base_zero;
        logic [1:0]       sector_size_code;
    } cfg_t;

    function automatic logic [7:0] den_sel(input logic [1:0] card, input logic [2:0] den);
        logic [7:0] r;
        r = SEL_NONE;
        case (card)
            CARD_FIRST: begin
                case (den)
                    DEN_SD:  r = 8'h20;
                    DEN_DD:  r = 8'h60;
                    DEN_HD:  r = 8'hFF;
                    DEN_8SD: r = 8'h20;
                    DEN_8DD: r = 8'h60;
                    default: r = SEL_NONE;
                endcase
            end
            CARD_SECOND: begin
                case (den)
                    DEN_SD:  r = 8'h10;
                    DEN_DD:  r = 8'h00;
                    DEN_HD:  r = 8'h20;
                    DEN_8SD: r = 8'h10;
                    DEN_8DD: r = 8'h20;
                    default: r = SEL_NONE;
                endcase
            end
            CARD_EIGHT: begin
                case (den)
                    DEN_SD:  r = 8'h10;
                    DEN_DD:  r = 8'h00;
                    DEN_HD:  r = 8'hA0;
                    DEN_8SD: r = 8'h50;
                    DEN_8DD: r = 8'h40;
                    default: r = SEL_NONE;
                endcase
            end
            default: r = SEL_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] side_sel_bit(input logic [1:0] card);
        logic [7:0] r;
        case (card)
            CARD_FIRST:  r = 8'h10;
            CARD_EIGHT:  r = 8'h08;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] side_cmd_bit(input logic [1:0] card);
        logic [7:0] r;
        case (card)
            CARD_SECOND: r = 8'h02;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cmd_byte(input logic [1:0] card, input logic rd);
        logic [7:0] r;
        case (card)
            CARD_SECOND: r = rd ? 8'h80 : 8'hA0;
            default:     r = rd ? 8'h88 : 8'hA8;
        endcase
        return r;
    endfunction

    // drive number modulo MAX_DRIVES by repeated subtraction on a 4-bit copy of the 3-bit value
    function automatic logic [2:0] drive_wrap(input logic [2:0] d);
        logic [3:0] r;
        logic [3:0] m;
        r = {1'b0, d};
        m = 4'(MAX_DRIVES);
        for (int i = 0; i < 8; i++) begin
            if (r >= m) begin
                r = r - m;
            end
        end
        return r[2:0];
    endfunction

endpackage

@@ design/fbcs_cfg.sv @@
// Configuration register bank on an APB-style port.
module fbcs_cfg
    import fbcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            case (idx)
                REG_CARD_TYPE:    cfg_next.card_type        = pwdata[1:0];
                REG_DRIVE_NUMBER: cfg_next.drive_number     = pwdata[2:0];
                REG_DENSITY_CODE: cfg_next.density_code     = pwdata[2:0];
                REG_SECTORS_SIDE: cfg_next.sectors_per_side = pwdata[SPS_W-1:0];
                REG_DOUBLE_SIDED: cfg_next.double_sided     = pwdata[0];
                REG_DOUBLE_STEP:  cfg_next.double_step      = pwdata[0];
                REG_SECTOR_BASE0: cfg_next.sector_base_zero = pwdata[0];
                REG_SECTOR_SIZE:  cfg_next.sector_size_code = pwdata[1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_CARD_TYPE:    prdata = 32'(cfg_reg.card_type);
            REG_DRIVE_NUMBER: prdata = 32'(cfg_reg.drive_number);
            REG_DENSITY_CODE: prdata = 32'(cfg_reg.density_code);
            REG_SECTORS_SIDE: prdata = 32'(cfg_reg.sectors_per_side);
            REG_DOUBLE_SIDED: prdata = 32'(cfg_reg.double_sided);
            REG_DOUBLE_STEP:  prdata = 32'(cfg_reg.double_step);
            REG_SECTOR_BASE0: prdata = 32'(cfg_reg.sector_base_zero);
            REG_SECTOR_SIZE:  prdata = 32'(cfg_reg.sector_size_code);
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.card_type        <= CARD_FIRST;
            cfg_reg.drive_number     <= 3'd0;
            cfg_reg.density_code     <= DEN_DD;
            cfg_reg.sectors_per_side <= SPS_W'(9);
            cfg_reg.double_sided     <= 1'b1;
            cfg_reg.double_step      <= 1'b0;
            cfg_reg.sector_base_zero <= 1'b0;
            cfg_reg.sector_size_code <= 2'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ design/fbcs_div.sv @@
// Restoring divider, one quotient bit per cycle: linear sector index by sectors per track.
module fbcs_div
    import fbcs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [SPT_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] quot,
    output logic [SPT_W-1:0] rem
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]     q_reg;
    logic [SPT_W-1:0]     r_reg;
    logic [SPT_W-1:0]     dvs_reg;
    logic [SPT_W:0]       r_sh;
    logic                 fits;

    assign r_sh  = {r_reg, q_reg[IDX_W-1]};
    assign fits  = r_sh >= {1'b0, dvs_reg};
    assign done  = done_reg;
    assign quot  = q_reg;
    assign rem   = r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(IDX_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            r_reg   <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[IDX_W-2:0], fits};
            r_reg <= fits ? SPT_W'(r_sh - {1'b0, dvs_reg}) : r_sh[SPT_W-1:0];
        end
    end

endmodule

@@ design/floppy_block_to_chs_sequencer_top.sv @@
// Top level: request intake, sector sequencer and result register.
//
//  channel   dir  handshake            payload
//  s_        in   s_tvalid/s_tready    s_tdata, s_tuser
//  m_        out  m_tvalid/m_tready    m_tdata, m_tuser, m_tlast
//  apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// A request is accepted, then divided in the divider (one quotient bit per
// cycle), then track and remainder are loaded, then the sector results,
// 0 to 64 of them, are loaded into the output register one at a time.
// Each result waits in the output register while m_tready is low; the
// sequencer holds until it is taken. s_tready is high only when idle.
// Synchronous active-low reset clears control state and the configuration registers; data registers are not reset.
module floppy_block_to_chs_sequencer_top
    import fbcs_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_PER_REQUEST
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // start_block[15:0], block_count[20:16], zero pad
    input  logic              s_tuser,   // direction
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // track, sector, head, select, command, offset, pad
    output logic [1:0]        m_tuser,   // status
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int LEFT_W = $clog2(4 * MAX_BLOCKS + 1);

    cfg_t             cfg;
    seq_state_t       state_reg;
    seq_state_t       state_next;
    logic             accept;
    logic             load;
    logic             div_done;
    logic [IDX_W-1:0] div_quot;
    logic [SPT_W-1:0] div_rem;

    logic [1:0]       bs;
    logic [SPS_W-1:0] sps;
    logic [SPT_W-1:0] spt;
    logic [IDX_W-1:0] idx_in;
    logic [4:0]       cnt_in;
    logic [LEFT_W-1:0] cnt_sat;

    logic             dir_reg;
    logic [LEFT_W-1:0] left_reg;
    logic [OFF_W-1:0] off_reg;
    logic [IDX_W:0]   trk_reg;
    logic [SPT_W-1:0] rem_reg;

    logic [47:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;
    logic             m_tvalid_reg;

    logic [7:0]       base_sel;
    logic [2:0]       drv;
    logic             bad;
    logic [7:0]       sel;
    logic [7:0]       cmd;
    logic [IDX_W+1:0] trk2;
    logic             over;
    logic             side;
    logic [SPT_W-1:0] sec;
    logic [7:0]       r_track;
    logic [7:0]       r_sector;
    logic [7:0]       r_sel;
    logic [7:0]       r_cmd;
    logic [1:0]       r_status;
    logic [SPT_W-1:0] rem_inc;

    fbcs_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbcs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .dividend (idx_in),
        .divisor  (spt),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign bs      = (cfg.sector_size_code >= 2'd2) ? 2'd2 : cfg.sector_size_code;
    assign sps     = (cfg.sectors_per_side == '0) ? SPS_W'(1) : cfg.sectors_per_side;
    assign spt     = cfg.double_sided ? {sps, 1'b0} : {1'b0, sps};
    assign idx_in  = IDX_W'(s_tdata[15:0]) << bs;
    assign cnt_in  = s_tdata[20:16];
    assign cnt_sat = (cnt_in > 5'(MAX_BLOCKS)) ? LEFT_W'(MAX_BLOCKS) : LEFT_W'(cnt_in);
    assign accept  = s_tvalid && s_tready;

    // per-sector result fields
    always_comb begin
        base_sel = den_sel(cfg.card_type, cfg.density_code);
        drv      = drive_wrap(cfg.drive_number);
        bad      = (cfg.card_type > CARD_EIGHT) || (cfg.density_code > DEN_8DD)
                   || (base_sel == SEL_NONE);
        if (cfg.card_type == CARD_EIGHT) begin
            sel = base_sel | {5'd0, drv};
        end else begin
            sel = base_sel | (8'd1 << drv[1:0]);
        end
        cmd      = cmd_byte(cfg.card_type, dir_reg);
        trk2     = cfg.double_step ? {trk_reg, 1'b0} : {1'b0, trk_reg};
        over     = trk2 > (IDX_W+2)'(255);
        side     = cfg.double_sided && (rem_reg >= {1'b0, sps});
        sec      = side ? (rem_reg - {1'b0, sps}) : rem_reg;
        r_track  = over ? 8'hFF : trk2[7:0];
        r_sector = 8'(sec) + (cfg.sector_base_zero ? 8'd0 : 8'd1);
        if (bad) begin
            r_sel    = 8'd0;
            r_cmd    = 8'd0;
            r_status = STATUS_BADDEN;
        end else begin
            r_sel    = side ? (sel | side_sel_bit(cfg.card_type)) : sel;
            r_cmd    = side ? (cmd | side_cmd_bit(cfg.card_type)) : cmd;
            r_status = over ? STATUS_TRACK : STATUS_OK;
        end
        rem_inc  = rem_reg + 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) state_next = (left_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (load && left_reg == LEFT_W'(1)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        load     = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: load = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                load     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            left_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept) begin
                left_reg <= cnt_sat << bs;
            end else if (load) begin
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dir_reg <= s_tuser;
            off_reg <= '0;
        end else if (load) begin
            off_reg <= off_reg + (OFF_W'(512) >> bs);
        end
        if (div_done) begin
            trk_reg <= {1'b0, div_quot};
            rem_reg <= div_rem;
        end else if (load) begin
            if (rem_inc == spt) begin
                rem_reg <= '0;
                trk_reg <= trk_reg + 1'b1;
            end else begin
                rem_reg <= rem_inc;
            end
        end
        if (load) begin
            m_tdata_reg <= {2'b00, off_reg, r_cmd, r_sel, side, r_sector, r_track};
            m_tuser_reg <= r_status;
            m_tlast_reg <= (left_reg == LEFT_W'(1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_emit_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> left_reg != '0)
        else $error("sequencer emitting with no sectors left");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_bad_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        load && bad |=> m_tdata[32:17] == 16'd0 && m_tuser == STATUS_BADDEN)
        else $error("unsupported density result carries select or command bits");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("request taken while busy");

endmodule

@@ dv/floppy_block_to_chs_sequencer_top_test.sv @@
// Self-checking testbench for the floppy block-to-CHS sector sequencer.
`timescale 1ns / 100ps

module floppy_block_to_chs_sequencer_top_test;
    import fbcs_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int SETUP_COUNT  = 9;
    localparam int HALF_PHASE   = 21;
    localparam int REPORT_LIMIT = 10;

    localparam logic [1:0] CARD_NONE   = 2'd3;
    localparam logic [2:0] DEN_UNKNOWN = 3'd7;
    localparam logic [1:0] SIZE_512    = 2'd0;
    localparam logic [1:0] SIZE_256    = 2'd1;
    localparam logic [1:0] SIZE_128    = 2'd2;
    localparam logic [1:0] SIZE_ODD    = 2'd3;

    // rows by card, eight-drive card first; entries density 4 down to 0
    localparam logic [2:0][4:0][7:0] SEL_BY_CARD = {
        {8'h40, 8'h50, 8'hA0, 8'h00, 8'h10},
        {8'h20, 8'h10, 8'h20, 8'h00, 8'h10},
        {8'h60, 8'h20, 8'hFF, 8'h60, 8'h20}
    };
    localparam logic [2:0][7:0] SIDE_SEL  = {8'h08, 8'h00, 8'h10};
    localparam logic [2:0][7:0] SIDE_CMD  = {8'h00, 8'h02, 8'h00};
    localparam logic [2:0][7:0] READ_CMD  = {8'h88, 8'h80, 8'h88};
    localparam logic [2:0][7:0] WRITE_CMD = {8'hA8, 8'hA0, 8'hA8};

    typedef struct packed {
        logic        rd;
        logic [15:0] first;
        logic [4:0]  blocks;
    } block_req_t;

    typedef struct packed {
        logic [7:0]  track;
        logic [7:0]  sector;
        logic        head;
        logic [7:0]  select;
        logic [7:0]  command;
        logic [12:0] offset;
        logic        last;
        logic [1:0]  status;
    } chs_result_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [47:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    cfg_t              disk_cfg;
    block_req_t        request_backlog[$];
    chs_result_t       due_sectors[$];
    chs_result_t       got;
    chs_result_t       want;
    block_req_t        next_req;
    logic              req_taken;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                requests_sent;
    int                requests_taken;
    int                sectors_seen;
    int                fault_count;

    floppy_block_to_chs_sequencer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic string show(input chs_result_t r);
        return $sformatf("trk %h sec %h side %b sel %h cmd %h off %h last %b status %h",
                         r.track, r.sector, r.head, r.select, r.command, r.offset,
                         r.last, r.status);
    endfunction

    task automatic plan_sectors(input logic rd, input logic [15:0] first_block,
                                input logic [4:0] blocks);
        int          shift;
        int          per_side;
        int          per_track;
        int          count;
        int          idx;
        int          left;
        int          offs;
        int          sect;
        int          trk;
        logic        bad;
        logic [7:0]  sel;
        logic [7:0]  cmd;
        chs_result_t r;
        shift     = (disk_cfg.sector_size_code >= SIZE_128) ? 2 : int'(disk_cfg.sector_size_code);
        per_side  = (disk_cfg.sectors_per_side == 0) ? 1 : int'(disk_cfg.sectors_per_side);
        per_track = disk_cfg.double_sided ? 2 * per_side : per_side;
        count     = (blocks > MAX_BLOCKS_PER_REQUEST) ? MAX_BLOCKS_PER_REQUEST : int'(blocks);
        idx       = int'(first_block) << shift;
        left      = count << shift;
        offs      = 0;
        sel       = 8'h00;
        cmd       = 8'h00;
        bad       = (disk_cfg.card_type > CARD_EIGHT) || (disk_cfg.density_code > DEN_8DD);
        if (!bad) begin
            sel = SEL_BY_CARD[disk_cfg.card_type][disk_cfg.density_code];
            if (sel == SEL_NONE) begin
                bad = 1'b1;
            end else begin
                if (disk_cfg.card_type == CARD_EIGHT) begin
                    sel = sel | {5'b0, disk_cfg.drive_number};
                end else begin
                    sel = sel | (8'h01 << disk_cfg.drive_number[1:0]);
                end
                cmd = rd ? READ_CMD[disk_cfg.card_type] : WRITE_CMD[disk_cfg.card_type];
            end
        end
        while (left != 0) begin
            sect = idx % per_track;
            trk  = idx / per_track;
            if (disk_cfg.double_step) begin
                trk = trk * 2;
            end
            r.head = 1'b0;
            if (disk_cfg.double_sided && sect >= per_side) begin
                sect   = sect - per_side;
                r.head = 1'b1;
            end
            r.select  = sel;
            r.command = cmd;
            r.status  = STATUS_OK;
            if (bad) begin
                r.status  = STATUS_BADDEN;
                r.select  = 8'h00;
                r.command = 8'h00;
            end else begin
                if (r.head) begin
                    r.select  = r.select | SIDE_SEL[disk_cfg.card_type];
                    r.command = r.command | SIDE_CMD[disk_cfg.card_type];
                end
                if (trk > 255) begin
                    r.status = STATUS_TRACK;
                end
            end
            r.track  = (trk > 255) ? 8'hFF : 8'(trk);
            r.sector = 8'(sect + (disk_cfg.sector_base_zero ? 0 : 1));
            r.offset = 13'(offs);
            r.last   = (left == 1);
            due_sectors.push_back(r);
            idx  = idx + 1;
            left = left - 1;
            offs = (offs + (512 >> shift)) % 8192;
        end
    endtask

    // request side: prediction happens on the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            plan_sectors(s_tuser, s_tdata[15:0], s_tdata[20:16]);
            requests_taken = requests_taken + 1;
            req_taken      = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            req_taken = 1'b0;
        end else if (!s_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = request_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {3'b000, next_req.blocks, next_req.first};
                s_tuser  <= next_req.rd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.track    = m_tdata[7:0];
            got.sector   = m_tdata[15:8];
            got.head     = m_tdata[16];
            got.select   = m_tdata[24:17];
            got.command  = m_tdata[32:25];
            got.offset   = m_tdata[45:33];
            got.last     = m_tlast;
            got.status   = m_tuser;
            sectors_seen = sectors_seen + 1;
            if (due_sectors.size() == 0) begin
                fault_count = fault_count + 1;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("unexpected sector transfer: %s", show(got));
                end
            end else begin
                want = due_sectors.pop_front();
                if (got !== want) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("sector mismatch at transfer %0d", sectors_seen);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_setup(input cfg_t c);
        apb_write(REG_CARD_TYPE, {6'b0, c.card_type});
        apb_write(REG_DRIVE_NUMBER, {5'b0, c.drive_number});
        apb_write(REG_DENSITY_CODE, {5'b0, c.density_code});
        apb_write(REG_SECTORS_SIDE, {2'b0, c.sectors_per_side});
        apb_write(REG_DOUBLE_SIDED, {7'b0, c.double_sided});
        apb_write(REG_DOUBLE_STEP, {7'b0, c.double_step});
        apb_write(REG_SECTOR_BASE0, {7'b0, c.sector_base_zero});
        apb_write(REG_SECTOR_SIZE, {6'b0, c.sector_size_code});
        disk_cfg = c;
    endtask

    function automatic cfg_t disk_setup(input int k);
        cfg_t c;
        case (k)
            0: c = '{CARD_FIRST,  3'd3, DEN_SD,      6'd18, 1'b1, 1'b1, 1'b1, SIZE_256};
            1: c = '{CARD_SECOND, 3'd2, DEN_HD,      6'd63, 1'b1, 1'b0, 1'b0, SIZE_128};
            2: c = '{CARD_EIGHT,  3'd7, DEN_8DD,     6'd1,  1'b0, 1'b1, 1'b1, SIZE_ODD};
            3: c = '{CARD_EIGHT,  3'd5, DEN_8SD,     6'd0,  1'b1, 1'b0, 1'b0, SIZE_512};
            4: c = '{CARD_FIRST,  3'd6, DEN_HD,      6'd26, 1'b0, 1'b0, 1'b0, SIZE_256};
            5: c = '{CARD_NONE,   3'd1, DEN_DD,      6'd10, 1'b1, 1'b1, 1'b1, SIZE_512};
            6: c = '{CARD_SECOND, 3'd4, DEN_UNKNOWN, 6'd5,  1'b1, 1'b0, 1'b0, SIZE_256};
            7: c = '{CARD_SECOND, 3'd0, DEN_DD,      6'd8,  1'b0, 1'b1, 1'b1, SIZE_128};
            default: c = '{CARD_EIGHT, 3'd0, DEN_HD, 6'd36, 1'b1, 1'b1, 1'b0, SIZE_256};
        endcase
        return c;
    endfunction

    task automatic queue_request(input logic rd, input logic [15:0] first,
                                 input logic [4:0] blocks);
        block_req_t q;
        q.rd     = rd;
        q.first  = first;
        q.blocks = blocks;
        request_backlog.push_back(q);
        requests_sent = requests_sent + 1;
    endtask

    task automatic queue_random(input int n);
        logic [15:0] first;
        logic [4:0]  blocks;
        repeat (n) begin
            first  = ($urandom_range(99) < 60) ? 16'($urandom_range(1023)) : 16'($urandom);
            blocks = ($urandom_range(99) < 88) ? 5'($urandom_range(16, 1))
                                               : 5'($urandom_range(31));
            queue_request(1'($urandom_range(1)), first, blocks);
        end
    endtask

    task automatic wait_quiet();
        while (requests_taken != requests_sent || due_sectors.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic settle();
        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin send_idle_pct = 66; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 66; end
            3: begin send_idle_pct = 38; recv_stall_pct = 38; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_taken      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        requests_sent  = 0;
        requests_taken = 0;
        sectors_seen   = 0;
        fault_count    = 0;
        disk_cfg       = '{CARD_FIRST, 3'd0, DEN_DD, 6'd9, 1'b1, 1'b0, 1'b0, SIZE_512};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setup: nine sectors a side, both sides, one-based
        queue_request(1'b1, 16'h0000, 5'd1);
        queue_request(1'b0, 16'h0000, 5'd16);
        queue_request(1'b1, 16'd8, 5'd3);
        queue_request(1'b0, 16'd4607, 5'd2);
        queue_request(1'b1, 16'hFFFF, 5'd1);
        queue_request(1'b0, 16'hFFFF, 5'd31);
        queue_request(1'b1, 16'h1234, 5'd0);
        queue_request(1'b0, 16'd100, 5'd17);
        queue_request(1'b1, 16'hAAAA, 5'h15);
        queue_request(1'b0, 16'h5555, 5'h0A);
        queue_request(1'b1, 16'd17, 5'd2);
        queue_request(1'b0, 16'd0, 5'd0);
        wait_quiet();

        for (int k = 0; k < SETUP_COUNT; k++) begin
            settle();
            load_setup(disk_setup(k));
            set_idling(k % 4);
            queue_random(HALF_PHASE);
            // sender holds off until the sequencer has drained
            wait_quiet();
            queue_random(HALF_PHASE);
        end
        settle();

        fault_count = fault_count + due_sectors.size();
        $display("%0d requests over %0d disk setups, %0d sector transfers checked",
                 requests_taken, SETUP_COUNT + 1, sectors_seen);
        $display("all cards, densities, sector sizes, sides and stepping under four idle mixes");
        if (fault_count == 0) begin
            $display("floppy_block_to_chs_sequencer_top_test OK");
        end else begin
            $display("floppy_block_to_chs_sequencer_top_test NOT OK");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("timeout with %0d sector transfers outstanding", due_sectors.size());
        $display("floppy_block_to_chs_sequencer_top_test NOT OK");
        $finish;
    end

endmodule

@@ floppy_block_to_chs_sequencer_top.f @@
design/fbcs_pkg.sv
design/fbcs_cfg.sv
design/fbcs_div.sv
design/floppy_block_to_chs_sequencer_top.sv
dv/floppy_block_to_chs_sequencer_top_test.sv
